// ===== sv/dik_pkg.sv =====
// shared types, constants and helper functions of the delta inverse kinematics block
package dik_pkg;

  localparam int LEN_W        = 27;
  localparam int POS_W        = 28;
  localparam int PZ_W         = 29;
  localparam int ISQRT_STEPS  = 31;
  localparam int CORDIC_STEPS = 30;
  localparam int ARM_PRE      = 9;
  localparam int ARM_LAT      = ARM_PRE + ISQRT_STEPS + CORDIC_STEPS + 2;
  localparam int NUM_ARMS     = 3;

  localparam logic signed [63:0] PI_Q30   = 64'sd3373259426;
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

  localparam logic [2:0] REG_BASE_RADIUS     = 3'd0;
  localparam logic [2:0] REG_PLATFORM_RADIUS = 3'd1;
  localparam logic [2:0] REG_UPPER_ARM       = 3'd2;
  localparam logic [2:0] REG_LOWER_ARM       = 3'd3;
  localparam logic [2:0] REG_HEIGHT_OFFSET   = 3'd4;
  localparam logic [2:0] REG_JOINT_LOW       = 3'd5;
  localparam logic [2:0] REG_JOINT_HIGH      = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_WORKSPACE = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [PZ_W-1:0]  pz;
    logic signed [POS_W-1:0] d;
    logic [LEN_W-1:0]        l1;
    logic [LEN_W-1:0]        l2;
  } geom_t;

  typedef struct packed {
    logic bad;
    logic dzero;
    logic npos;
    logic nneg;
  } flag_t;

  function automatic logic signed [31:0] arm_cos(input int idx);
    logic signed [31:0] c;
    case (idx)
      0:       c = 32'sd1073741824;
      default: c = -32'sd536870912;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] arm_sin(input int idx);
    logic signed [31:0] s;
    case (idx)
      0:       s = 32'sd0;
      1:       s = 32'sd929887697;
      default: s = -32'sd929887697;
    endcase
    return s;
  endfunction

  function automatic logic signed [63:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] c);
    logic signed [63:0] p;
    p = 64'(a) * 64'(c);
    return (p + HALF_Q30) >>> 30;
  endfunction

  function automatic logic signed [32:0] atan_step(input int i);
    logic signed [32:0] v;
    case (i)
      0:       v = 33'sd843314856;
      1:       v = 33'sd497837829;
      2:       v = 33'sd263043836;
      3:       v = 33'sd133525158;
      4:       v = 33'sd67021686;
      5:       v = 33'sd33543515;
      6:       v = 33'sd16775850;
      7:       v = 33'sd8388437;
      8:       v = 33'sd4194282;
      9:       v = 33'sd2097149;
      default: v = (33'sd1 <<< (30 - i)) - 33'sd1;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] norm_shift(input logic [63:0] m);
    logic [6:0] len;
    len = 7'd0;
    for (int k = 0; k < 64; k++) begin
      if (m[k]) len = 7'(k + 1);
    end
    return (len > 7'd30) ? 6'(len - 7'd30) : 6'd0;
  endfunction

endpackage

// ===== sv/dik_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module dik_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] v_in,
  output logic [31:0] root
);
  import dik_pkg::*;

  logic [61:0] rv [0:ISQRT_STEPS];
  logic [61:0] rr [0:ISQRT_STEPS];

  assign rv[0] = v_in;
  assign rr[0] = '0;

  for (genvar t = 0; t < ISQRT_STEPS; t++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (2 * (ISQRT_STEPS - 1 - t));
    logic [61:0] sum;
    assign sum = rr[t] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rv[t] >= sum) begin
          rv[t+1] <= rv[t] - sum;
          rr[t+1] <= (rr[t] >> 1) + BIT;
        end else begin
          rv[t+1] <= rv[t];
          rr[t+1] <= rr[t] >> 1;
        end
      end
    end
  end

  assign root = rr[ISQRT_STEPS][31:0];

endmodule

// ===== sv/dik_cordic.sv =====
// pipelined vectoring cordic, atan in q30, one rotation per stage
module dik_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [35:0] x_in,
  input  logic signed [35:0] y_in,
  output logic signed [32:0] z_out
);
  import dik_pkg::*;

  logic signed [35:0] cx [0:CORDIC_STEPS];
  logic signed [35:0] cy [0:CORDIC_STEPS];
  logic signed [32:0] cz [0:CORDIC_STEPS];

  assign cx[0] = x_in;
  assign cy[0] = y_in;
  assign cz[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [32:0] ANG = atan_step(i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][35]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ANG;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ANG;
        end
      end
    end
  end

  assign z_out = cz[CORDIC_STEPS];

endmodule

// ===== sv/dik_arm.sv =====
// one arm: i, j, k terms, normalisation, discriminant, square root and angle
module dik_arm #(
  parameter int FRAC_BITS = 16,
  parameter int ARM       = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  dik_pkg::geom_t         geom,
  output logic signed [FRAC_BITS+2:0] ang,
  output logic                   bad
);
  import dik_pkg::*;

  localparam int AW = FRAC_BITS + 3;
  localparam logic signed [31:0] COS = arm_cos(ARM);
  localparam logic signed [31:0] SIN = arm_sin(ARM);
  localparam logic signed [63:0] PI_WIDE =
    (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  localparam logic signed [AW-1:0] PI_Q = AW'(PI_WIDE);

  logic signed [POS_W-1:0] a1_px, a1_py;
  logic signed [28:0]      a1_cd, a1_sd;
  logic signed [57:0]      a1_jv, a2_jv, a3_jv, a4_jv, a5_jv, a6_jv;
  logic signed [59:0]      a1_kc, a2_kc, a3_kc;
  logic [LEN_W-1:0]        a1_l1, a2_l1, a3_l1, a4_l1;
  logic signed [29:0]      a2_dx, a2_dy;
  logic signed [30:0]      a3_mx, a3_my, a4_w;
  logic signed [60:0]      a3_dx2, a3_dy2;
  logic signed [63:0]      a4_kv, a5_kv, a6_kv, a5_iv, a6_iv;
  logic [5:0]              a6_s;
  logic signed [31:0]      a7_i, a7_j, a7_k, a8_j, a9_j;
  logic signed [61:0]      a8_i2, a8_j2, a8_k2;
  logic signed [32:0]      a8_den, a9_den;
  logic [61:0]             a9_disc;
  logic                    a9_bad;

  logic signed [LEN_W:0]   l1s, l2s;
  logic signed [63:0]      abs_i, abs_j, abs_k, m_ij, m_all;
  logic signed [62:0]      dsc;

  assign l1s = $signed({1'b0, geom.l1});
  assign l2s = $signed({1'b0, geom.l2});

  always_ff @(posedge clk) begin
    if (en) begin
      a1_px <= geom.px;
      a1_py <= geom.py;
      a1_cd <= 29'(mul_q30(32'(geom.d), COS));
      a1_sd <= 29'(mul_q30(32'(geom.d), SIN));
      a1_jv <= (58'(l1s) * 58'(geom.pz)) <<< 1;
      a1_kc <= 60'(geom.pz) * 60'(geom.pz) + 60'(l1s) * 60'(l1s) - 60'(l2s) * 60'(l2s);
      a1_l1 <= geom.l1;

      a2_dx <= 30'(a1_px) + 30'(a1_cd);
      a2_dy <= 30'(a1_py) + 30'(a1_sd);
      a2_jv <= a1_jv;
      a2_kc <= a1_kc;
      a2_l1 <= a1_l1;

      a3_mx  <= 31'(mul_q30(32'(a2_dx), COS));
      a3_my  <= 31'(mul_q30(32'(a2_dy), SIN));
      a3_dx2 <= 61'(a2_dx) * 61'(a2_dx);
      a3_dy2 <= 61'(a2_dy) * 61'(a2_dy);
      a3_jv  <= a2_jv;
      a3_kc  <= a2_kc;
      a3_l1  <= a2_l1;

      a4_w  <= a3_mx + a3_my;
      a4_kv <= 64'(a3_dx2) + 64'(a3_dy2) + 64'(a3_kc);
      a4_jv <= a3_jv;
      a4_l1 <= a3_l1;

      a5_iv <= (64'($signed({1'b0, a4_l1})) * 64'(a4_w)) <<< 1;
      a5_kv <= a4_kv;
      a5_jv <= a4_jv;

      a6_s  <= norm_shift(m_all);
      a6_iv <= a5_iv;
      a6_jv <= a5_jv;
      a6_kv <= a5_kv;

      a7_i <= 32'(a6_iv >>> a6_s);
      a7_j <= 32'(64'(a6_jv) >>> a6_s);
      a7_k <= 32'(a6_kv >>> a6_s);

      a8_i2  <= 62'(a7_i) * 62'(a7_i);
      a8_j2  <= 62'(a7_j) * 62'(a7_j);
      a8_k2  <= 62'(a7_k) * 62'(a7_k);
      a8_j   <= a7_j;
      a8_den <= 33'(a7_k) + 33'(a7_i);

      a9_disc <= dsc[61:0];
      a9_bad  <= dsc[62];
      a9_j    <= a8_j;
      a9_den  <= a8_den;
    end
  end

  always_comb begin
    abs_i = a5_iv[63] ? -a5_iv : a5_iv;
    abs_j = a5_jv[57] ? -64'(a5_jv) : 64'(a5_jv);
    abs_k = a5_kv[63] ? -a5_kv : a5_kv;
    m_ij  = (abs_j > abs_i) ? abs_j : abs_i;
    m_all = (abs_k > m_ij) ? abs_k : m_ij;
    dsc   = 63'(a8_j2) + 63'(a8_i2) - 63'(a8_k2);
  end

  // square root with side data carried alongside
  logic [31:0]        root;
  logic signed [31:0] sj   [0:ISQRT_STEPS-1];
  logic signed [32:0] sden [0:ISQRT_STEPS-1];
  logic               sbad [0:ISQRT_STEPS-1];

  dik_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .v_in (a9_disc),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sj[0]   <= a9_j;
      sden[0] <= a9_den;
      sbad[0] <= a9_bad;
      for (int k = 1; k < ISQRT_STEPS; k++) begin
        sj[k]   <= sj[k-1];
        sden[k] <= sden[k-1];
        sbad[k] <= sbad[k-1];
      end
    end
  end

  logic signed [32:0] num;
  logic signed [35:0] den_w, num_w, n_x, n_y;
  flag_t              n_f;

  always_comb begin
    num   = -33'(sj[ISQRT_STEPS-1]) - $signed({1'b0, root});
    den_w = 36'(sden[ISQRT_STEPS-1]);
    num_w = 36'(num);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_x       <= den_w[35] ? -den_w : den_w;
      n_y       <= den_w[35] ? -num_w : num_w;
      n_f.bad   <= sbad[ISQRT_STEPS-1];
      n_f.dzero <= (den_w == '0);
      n_f.npos  <= !num[32] && (num != '0);
      n_f.nneg  <= num[32];
    end
  end

  logic signed [32:0] cz;
  flag_t              sf [0:CORDIC_STEPS-1];

  dik_cordic u_cordic (
    .clk   (clk),
    .en    (en),
    .x_in  (n_x),
    .y_in  (n_y),
    .z_out (cz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sf[0] <= n_f;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
        sf[k] <= sf[k-1];
      end
    end
  end

  logic signed [34:0] rnd;
  flag_t              lf;

  always_comb begin
    lf  = sf[CORDIC_STEPS-1];
    rnd = (35'($signed({cz, 1'b0})) + (35'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bad <= lf.bad;
      if (lf.dzero) begin
        if (lf.npos) begin
          ang <= PI_Q;
        end else if (lf.nneg) begin
          ang <= -PI_Q;
        end else begin
          ang <= '0;
        end
      end else begin
        ang <= AW'(rnd);
      end
    end
  end

endmodule

// ===== sv/delta_inverse_kinematics.sv =====
// top level of the delta robot inverse kinematics pipeline
//
// channel  direction  signals                       content
// s_*      in         s_tvalid s_tready s_tdata     tool position and rotation
// m_*      out        m_tvalid m_tready m_tdata     joint angles, rotation, status
// cfg_*    in         cfg_wen cfg_index cfg_data    geometry and joint limits
//
// one transfer accepted per cycle while the output is not stalled
// the depth is set by the 31-stage square root and the 30-stage cordic per arm
// reset clears the stage valid bits and loads the default geometry and joint limit registers
// a stall at the output freezes every stage at once; nothing is lost or repeated
module delta_inverse_kinematics #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // pos_x, pos_y, pos_z, tool_rotation
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // joint_angle_1, joint_angle_2, joint_angle_3, rotation_out, status
  output logic [((3*(FRAC_BITS+3)+DATA_WIDTH+2+7)/8)*8-1:0] m_tdata,
  input  logic                  cfg_wen,
  input  logic [2:0]            cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data
);
  import dik_pkg::*;

  localparam int DW        = DATA_WIDTH;
  localparam int AW        = FRAC_BITS + 3;
  localparam int PRE_SHIFT = DW - 28;
  localparam int LAT       = ARM_LAT + 2;
  localparam int OUT_W     = ((3*AW+DW+2+7)/8)*8;

  logic [DW-2:0]          base_radius, platform_radius, upper_arm_length, lower_arm_length;
  logic signed [DW-1:0]   height_offset;
  logic signed [AW-1:0]   joint_low_limit, joint_high_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_radius      <= (DW-1)'(13107200);
      platform_radius  <= (DW-1)'(3276800);
      upper_arm_length <= (DW-1)'(13107200);
      lower_arm_length <= (DW-1)'(26214400);
      height_offset    <= '0;
      joint_low_limit  <= AW'(-102944);
      joint_high_limit <= AW'(102944);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BASE_RADIUS:     base_radius      <= cfg_data[DW-2:0];
        REG_PLATFORM_RADIUS: platform_radius  <= cfg_data[DW-2:0];
        REG_UPPER_ARM:       upper_arm_length <= cfg_data[DW-2:0];
        REG_LOWER_ARM:       lower_arm_length <= cfg_data[DW-2:0];
        REG_HEIGHT_OFFSET:   height_offset    <= $signed(cfg_data);
        REG_JOINT_LOW:       joint_low_limit  <= $signed(cfg_data[AW-1:0]);
        REG_JOINT_HIGH:      joint_high_limit <= $signed(cfg_data[AW-1:0]);
        default: ;
      endcase
    end
  end

  logic           en;
  logic [LAT-1:0] vld;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // front stage: height offset, radius difference, pre-shift of lengths and position
  logic signed [DW:0]  z_sum;
  logic [LEN_W-1:0]    lr, lb;
  geom_t               geom;
  logic signed [DW-1:0] rot [0:ARM_LAT];

  always_comb begin
    z_sum = (DW+1)'($signed(s_tdata[3*DW-1:2*DW])) + (DW+1)'(height_offset);
    lr    = LEN_W'(platform_radius >> PRE_SHIFT);
    lb    = LEN_W'(base_radius >> PRE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geom.px <= POS_W'($signed(s_tdata[DW-1:0]) >>> PRE_SHIFT);
      geom.py <= POS_W'($signed(s_tdata[2*DW-1:DW]) >>> PRE_SHIFT);
      geom.pz <= PZ_W'(z_sum >>> PRE_SHIFT);
      geom.d  <= $signed({1'b0, lr}) - $signed({1'b0, lb});
      geom.l1 <= LEN_W'(upper_arm_length >> PRE_SHIFT);
      geom.l2 <= LEN_W'(lower_arm_length >> PRE_SHIFT);
      rot[0]  <= $signed(s_tdata[4*DW-1:3*DW]);
      for (int k = 1; k <= ARM_LAT; k++) begin
        rot[k] <= rot[k-1];
      end
    end
  end

  logic signed [AW-1:0] ang [0:NUM_ARMS-1];
  logic [NUM_ARMS-1:0]  bad;
  logic [NUM_ARMS-1:0]  over;

  for (genvar a = 0; a < NUM_ARMS; a++) begin : g_arm
    dik_arm #(
      .FRAC_BITS (FRAC_BITS),
      .ARM       (a)
    ) u_arm (
      .clk  (clk),
      .en   (en),
      .geom (geom),
      .ang  (ang[a]),
      .bad  (bad[a])
    );
    assign over[a] = (ang[a] < joint_low_limit) || (ang[a] > joint_high_limit);
  end

  logic [1:0]           o_status, status_next;
  logic signed [AW-1:0] o_ang [0:NUM_ARMS-1];
  logic signed [DW-1:0] o_rot;

  always_comb begin
    if (|bad) begin
      status_next = ST_WORKSPACE;
    end else if (|over) begin
      status_next = ST_LIMIT;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_status <= status_next;
      o_rot    <= rot[ARM_LAT];
      for (int a = 0; a < NUM_ARMS; a++) begin
        o_ang[a] <= (status_next == ST_OK) ? ang[a] : '0;
      end
    end
  end

  assign m_tdata = OUT_W'({o_status, o_rot, o_ang[2], o_ang[1], o_ang[0]});

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (o_status == ST_OK || o_status == ST_WORKSPACE || o_status == ST_LIMIT))
    else $error("unknown status code");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status != ST_OK) |->
      (o_ang[0] == '0 && o_ang[1] == '0 && o_ang[2] == '0))
    else $error("angles not cleared on failure");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("stage valid bits moved during a stall");

endmodule
